FILE: src/ualla_pkg.sv
// ----------------------------------------------------------------------------
// ualla_pkg
// Shared widths, codes and helpers for the unaligned access line aligner.
// ----------------------------------------------------------------------------
package ualla_pkg;

    localparam int TAG_W   = 4;
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int STRB_W  = 8;
    localparam int STAT_W  = 3;
    localparam int ERR_W   = 3;
    localparam int OFF_MAX_W = 3;

    // input: tag, req_addr, req_len, strobe_len, req_wr, wdata,
    //        byte_enables, resp_status, line_rdata (200 bits, no padding)
    localparam int IN_TDATA_W  = 200;
    localparam int IN_TUSER_W  = 1;
    // output: tag_out, line_addr, line_strobe, line_wdata, write_out,
    //         rdata_out, status_out, error_code (195 bits) + zero fill
    localparam int OUT_FIELDS_W = TAG_W + ADDR_W + STRB_W + DATA_W + 1
                                + DATA_W + STAT_W + ERR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W  = 2;

    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_RESP = 1'b1;

    typedef enum logic [1:0] {
        OUT_ISSUE = 2'd0,
        OUT_RESP  = 2'd1,
        OUT_ERROR = 2'd2
    } t_out_kind;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_ZERO_LEN    = 3'd1,
        ERR_STRB_POW2   = 3'd2,
        ERR_DATA_POW2   = 3'd3,
        ERR_CROSS_LINE  = 3'd4,
        ERR_LEN_MISMATCH = 3'd5,
        ERR_UNKNOWN_TAG = 3'd6
    } t_err_code;

    typedef struct packed {
        logic [OFF_MAX_W-1:0] offset;
        logic [LEN_W-1:0]     len;
        logic                 wr;
    } t_tag_entry;

    function automatic logic is_pow2(input logic [LEN_W-1:0] v);
        return (v != '0) && ((v & (v - 1'b1)) == '0);
    endfunction

    // low n bits set, n saturates at STRB_W
    function automatic logic [STRB_W-1:0] lsb_mask(input logic [LEN_W-1:0] n);
        logic [STRB_W:0] m;
        m = '0;
        if (n >= LEN_W'(STRB_W)) begin
            m = '1;
        end else begin
            m = (9'd1 << n) - 9'd1;
        end
        return m[STRB_W-1:0];
    endfunction

    // low n bytes set, n saturates at 8 bytes
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [STRB_W-1:0] b;
        logic [DATA_W-1:0] m;
        b = lsb_mask(n);
        for (int i = 0; i < STRB_W; i++) begin
            m[i*8 +: 8] = {8{b[i]}};
        end
        return m;
    endfunction

endpackage

FILE: src/unaligned_access_line_aligner_core.sv
// ----------------------------------------------------------------------------
// unaligned_access_line_aligner_core
// Turns narrow byte requests into line-aligned requests and maps line
// responses back, tracking offset/length/direction per tag.
// ----------------------------------------------------------------------------
// channel   dir  tdata                               tuser
// s_axis    in   request or line response fields     kind (0 req, 1 resp)
// m_axis    out  issued request / response / error   out_kind
//
// One request per cycle sustained while m_axis_tready stays high; m_axis_tvalid
// rises once an accepted item has passed the input register and then the result register.
// The tag table is flip-flops written and read in the same single pass, so
// back-to-back items on one tag see each other's updates.
// Reset clears all tag valid bits and both valid flags; no clearing pass.
// A stall on m_axis holds the result register and backs up into s_axis_tready.
// ----------------------------------------------------------------------------
module unaligned_access_line_aligner_core #(
    parameter int LINE_BYTES = 8,
    parameter int NUM_TAGS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tag, req_addr, req_len, strobe_len, req_wr, wdata, byte_enables,
    // resp_status, line_rdata
    input  logic [ualla_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // kind
    input  logic [ualla_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tag_out, line_addr, line_strobe, line_wdata, write_out, rdata_out,
    // status_out, error_code, zero fill
    output logic [ualla_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // out_kind
    output logic [ualla_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import ualla_pkg::*;

    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int TBL_DEPTH = (NUM_TAGS < (1 << TAG_W)) ? NUM_TAGS : (1 << TAG_W);
    localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] ALIGN_MASK = ~ADDR_W'(LINE_BYTES - 1);
    localparam logic [LEN_W:0]    LINE_LEN   = (LEN_W+1)'(LINE_BYTES);

    // ---------------- input register ----------------
    logic                   r_in_valid;
    logic [IN_TDATA_W-1:0]  r_in_tdata;
    logic [IN_TUSER_W-1:0]  r_in_tuser;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic [OUT_TUSER_W-1:0] r_m_tuser;

    logic w_adv;
    logic w_fire;

    assign w_adv         = !r_m_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    // unpacked fields of the held item
    logic                 w_kind;
    logic [TAG_W-1:0]     w_tag;
    logic [ADDR_W-1:0]    w_addr;
    logic [LEN_W-1:0]     w_dlen;
    logic [LEN_W-1:0]     w_slen;
    logic                 w_wr_req;
    logic [DATA_W-1:0]    w_wdata;
    logic [STRB_W-1:0]    w_be;
    logic [STAT_W-1:0]    w_status;
    logic [DATA_W-1:0]    w_line;

    assign w_kind     = r_in_tuser[0];
    assign w_tag      = r_in_tdata[3:0];
    assign w_addr     = r_in_tdata[51:4];
    assign w_dlen     = r_in_tdata[55:52];
    assign w_slen     = r_in_tdata[59:56];
    assign w_wr_req   = r_in_tdata[60];
    assign w_wdata    = r_in_tdata[124:61];
    assign w_be       = r_in_tdata[132:125];
    assign w_status   = r_in_tdata[135:133];
    assign w_line     = r_in_tdata[199:136];

    // ---------------- tag table ----------------
    logic [TBL_DEPTH-1:0] r_tbl_vld;
    t_tag_entry           r_tbl [TBL_DEPTH];

    logic                 w_tag_ok;
    logic [IDX_W-1:0]     w_idx;
    t_tag_entry           w_ent;
    logic                 w_ent_vld;

    assign w_tag_ok  = (9'(w_tag) < 9'(NUM_TAGS));
    assign w_idx     = IDX_W'(w_tag);
    assign w_ent     = r_tbl[w_idx];
    assign w_ent_vld = r_tbl_vld[w_idx];

    // ---------------- single-pass datapath ----------------
    logic [OFF_MAX_W-1:0] w_off;
    logic [LEN_W:0]       w_dsum;
    logic [LEN_W:0]       w_ssum;
    t_err_code            w_err;
    t_out_kind            w_okind;
    logic                 w_issue;
    logic                 w_resp_ok;
    logic [ADDR_W-1:0]    w_aligned;
    logic [STRB_W-1:0]    w_strb_raw;
    logic [STRB_W-1:0]    w_strobe;
    logic [DATA_W-1:0]    w_lwdata;
    logic                 w_wr_out;
    logic [DATA_W-1:0]    w_rdata;
    logic [STAT_W-1:0]    w_stat_out;

    assign w_off  = OFF_MAX_W'(w_addr[OFF_W-1:0]);
    assign w_dsum = (LEN_W+1)'(w_off) + (LEN_W+1)'(w_dlen);
    assign w_ssum = (LEN_W+1)'(w_off) + (LEN_W+1)'(w_slen);

    always_comb begin
        w_err      = ERR_NONE;
        w_okind    = OUT_ERROR;
        w_issue    = 1'b0;
        w_resp_ok  = 1'b0;
        w_aligned  = '0;
        w_strb_raw = '0;
        w_strobe   = '0;
        w_lwdata   = '0;
        w_wr_out   = 1'b0;
        w_rdata    = '0;
        w_stat_out = '0;
        if (!w_tag_ok) begin
            w_err = ERR_UNKNOWN_TAG;
        end else if (w_kind == KIND_REQ) begin
            // first failing check wins
            if (w_dlen == '0) begin
                w_err = ERR_ZERO_LEN;
            end else if (w_slen != '0 && !is_pow2(w_slen)) begin
                w_err = ERR_STRB_POW2;
            end else if (!is_pow2(w_dlen)) begin
                w_err = ERR_DATA_POW2;
            end else if (w_dsum > LINE_LEN || w_ssum > LINE_LEN) begin
                w_err = ERR_CROSS_LINE;
            end else if (w_slen != '0 && w_slen != w_dlen) begin
                w_err = ERR_LEN_MISMATCH;
            end
            if (w_err == ERR_NONE) begin
                w_issue   = 1'b1;
                w_okind   = OUT_ISSUE;
                w_aligned = w_addr & ALIGN_MASK;
                w_wr_out  = w_wr_req;
                if (w_wr_req) begin
                    // no enables given: enable all data length bytes
                    w_strb_raw = (w_slen != '0) ? (w_be & lsb_mask(w_slen))
                                                : lsb_mask(w_dlen);
                    w_strobe   = (w_strb_raw << w_off)
                               & lsb_mask(LEN_W'(LINE_BYTES));
                    w_lwdata   = (w_wdata & byte_mask(w_dlen)) << {w_off, 3'b000};
                end
            end
        end else begin
            if (!w_ent_vld) begin
                w_err = ERR_UNKNOWN_TAG;
            end else begin
                w_resp_ok  = 1'b1;
                w_okind    = OUT_RESP;
                w_wr_out   = w_ent.wr;
                w_stat_out = w_status;
                if (!w_ent.wr) begin
                    w_rdata = ((w_line & byte_mask(LEN_W'(LINE_BYTES)))
                               >> {w_ent.offset, 3'b000}) & byte_mask(w_ent.len);
                end
            end
        end
    end

    logic [OUT_TDATA_W-1:0] n_m_tdata;
    assign n_m_tdata = {{OUT_PAD_W{1'b0}}, w_err, w_stat_out, w_rdata, w_wr_out,
                        w_lwdata, w_strobe, w_aligned, w_tag};

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_tbl_vld  <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_m_valid <= r_in_valid;
            end
            if (w_fire && w_issue) begin
                r_tbl_vld[w_idx] <= 1'b1;
            end else if (w_fire && w_resp_ok) begin
                r_tbl_vld[w_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_tdata <= s_axis_tdata;
            r_in_tuser <= s_axis_tuser;
        end
        if (w_fire) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= w_okind;
        end
        if (w_fire && w_issue) begin
            r_tbl[w_idx] <= '{offset: w_off, len: w_dlen, wr: w_wr_req};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // ---------------- assertions ----------------
    a_issue_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_issue) |=> r_tbl_vld[$past(w_idx)])
        else $error("issued request did not mark its tag outstanding");

    a_resp_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_resp_ok) |=> !r_tbl_vld[$past(w_idx)])
        else $error("returned response left its tag outstanding");

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == OUT_ERROR) |-> (m_axis_tdata[194:192] != ERR_NONE))
        else $error("error result without an error code");

    a_ok_has_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != OUT_ERROR) |-> (m_axis_tdata[194:192] == ERR_NONE))
        else $error("good result carries an error code");

    a_read_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == OUT_ISSUE && !m_axis_tdata[124])
        |-> (m_axis_tdata[59:52] == '0 && m_axis_tdata[123:60] == '0))
        else $error("issued read carries strobes or write data");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_m_valid && !m_axis_tready))
        else $error("input stalled without a full pipeline");

endmodule
